FILE: src/mse_pkg.sv
package mse_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned MAX_ITEMS_DEF = 64;
  // largest run the index widths are sized for
  localparam int unsigned MAX_ITEMS_CAP = 64;
  localparam int unsigned ADDR_W        = $clog2(MAX_ITEMS_CAP);
  localparam int unsigned CNT_W         = ADDR_W + 1;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);

  // one classified input transaction on its way to the sort engine
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [ADDR_W-1:0]        idx;
    logic                     store;
    logic                     last;
    logic                     ovf;
  } q_entry_t;

endpackage

FILE: src/mse_front.sv
module mse_front #(
  parameter int unsigned MAX_ITEMS = mse_pkg::MAX_ITEMS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic signed [mse_pkg::DATA_W-1:0] value_i,
  input  logic                             last_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output mse_pkg::q_entry_t                q_entry_o
);

  logic [mse_pkg::CNT_W-1:0] count_q, count_d;
  logic                      ovf_q, ovf_d;
  logic                      accept;
  logic                      store;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign q_push_o   = accept;
  assign store      = count_q < mse_pkg::CNT_W'(MAX_ITEMS);

  always_comb begin
    q_entry_o.value = value_i;
    q_entry_o.idx   = count_q[mse_pkg::ADDR_W-1:0];
    q_entry_o.store = store;
    q_entry_o.last  = last_i;
    q_entry_o.ovf   = ovf_q || !store;
  end

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (accept) begin
      if (last_i) begin
        count_d = '0;
        ovf_d   = 1'b0;
      end else begin
        count_d = count_q + mse_pkg::CNT_W'(store);
        ovf_d   = ovf_q || !store;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

FILE: src/mse_queue.sv
module mse_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mse_pkg::q_entry_t entry_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              stall_i,
  output mse_pkg::q_entry_t entry_o
);

  mse_pkg::q_entry_t           slots_q [mse_pkg::QUEUE_DEPTH];
  logic [mse_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [mse_pkg::QPTR_W:0]    cnt_q;
  logic                        pop;

  assign full_o  = cnt_q == (mse_pkg::QPTR_W+1)'(mse_pkg::QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign entry_o = slots_q[rd_ptr_q];
  assign pop     = valid_o && !stall_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: src/mse_back.sv
module mse_back #(
  parameter int unsigned MAX_ITEMS = mse_pkg::MAX_ITEMS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  output logic                              q_stall_o,
  input  mse_pkg::q_entry_t                 q_entry_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [mse_pkg::DATA_W-1:0] sorted_value_o,
  output logic                              final_res_o,
  output logic                              dropped_o
);

  localparam int unsigned DW = mse_pkg::DATA_W;
  localparam int unsigned AW = mse_pkg::ADDR_W;
  localparam int unsigned CW = mse_pkg::CNT_W;
  localparam int unsigned SW = CW + 1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETUP,
    ST_MERGE,
    ST_OUT
  } state_e;

  function automatic logic [CW-1:0] min_cnt(input logic [SW-1:0] a, input logic [CW-1:0] n);
    min_cnt = (a > {1'b0, n}) ? n : a[CW-1:0];
  endfunction

  state_e          state_q, state_d;
  logic [CW-1:0]   n_q, n_d;
  logic            drop_q, drop_d;
  logic [CW-1:0]   w_q, w_d;
  logic [CW-1:0]   mid_q, mid_d;
  logic [CW-1:0]   hi_q, hi_d;
  logic [CW-1:0]   i_q, i_d;
  logic [CW-1:0]   j_q, j_d;
  logic [CW-1:0]   k_q, k_d;
  logic            src_q, src_d;
  logic            ov_q, ov_d;
  logic [DW-1:0]   oval_q, oval_d;
  logic            ofin_q, ofin_d;
  logic            odrop_q, odrop_d;

  // ping-pong buffers: a holds the loaded run, passes alternate between them
  logic [DW-1:0]   mem_a [MAX_ITEMS];
  logic [DW-1:0]   mem_b [MAX_ITEMS];
  logic [DW-1:0]   rd_a_i_q, rd_a_j_q, rd_b_i_q, rd_b_j_q;
  logic [AW-1:0]   ra_i, ra_j;

  logic            wa_en, wb_en;
  logic [AW-1:0]   w_addr;
  logic [DW-1:0]   w_data;

  logic signed [DW-1:0] va, vb;
  logic            pop;
  logic            take_j;
  logic            adv;
  logic [CW-1:0]   k_inc;
  logic [CW-1:0]   i_inc;
  logic [SW-1:0]   w2;
  logic [SW-1:0]   sum_mid, sum_hi;

  assign va = src_q ? rd_b_i_q : rd_a_i_q;
  assign vb = src_q ? rd_b_j_q : rd_a_j_q;

  assign q_stall_o = state_q != ST_LOAD;
  assign pop       = q_valid_i && (state_q == ST_LOAD);
  assign take_j    = (j_q < hi_q) && ((i_q >= mid_q) || (vb < va));
  assign adv       = !ov_q || !out_stall_i;
  assign k_inc     = k_q + 1'b1;
  assign i_inc     = i_q + 1'b1;
  assign w2        = {1'b0, w_q} << 1;
  assign sum_mid   = {1'b0, hi_q} + {1'b0, w_q};
  assign sum_hi    = {1'b0, hi_q} + ({1'b0, w_q} << 1);

  // reads are issued from next-state pointers so the head data is ready once those pointers are registered
  assign ra_i = i_d[AW-1:0];
  assign ra_j = j_d[AW-1:0];

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    drop_d  = drop_q;
    w_d     = w_q;
    mid_d   = mid_q;
    hi_d    = hi_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    src_d   = src_q;
    ov_d    = ov_q;
    oval_d  = oval_q;
    ofin_d  = ofin_q;
    odrop_d = odrop_q;
    wa_en   = 1'b0;
    wb_en   = 1'b0;
    w_addr  = q_entry_i.idx;
    w_data  = q_entry_i.value;

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      ST_LOAD: begin
        if (pop) begin
          wa_en = q_entry_i.store;
          if (q_entry_i.last) begin
            n_d     = q_entry_i.store ? ({1'b0, q_entry_i.idx} + 1'b1) : CW'(MAX_ITEMS);
            drop_d  = q_entry_i.ovf;
            src_d   = 1'b0;
            state_d = ST_SETUP;
          end
        end
      end

      ST_SETUP: begin
        i_d = '0;
        if (n_q == CW'(1)) begin
          state_d = ST_OUT;
        end else begin
          w_d     = CW'(1);
          mid_d   = CW'(1);
          hi_d    = CW'(2);
          j_d     = CW'(1);
          k_d     = '0;
          state_d = ST_MERGE;
        end
      end

      ST_MERGE: begin
        w_addr = k_q[AW-1:0];
        w_data = take_j ? vb : va;
        wa_en  = src_q;
        wb_en  = !src_q;
        if (take_j) begin
          j_d = j_q + 1'b1;
        end else begin
          i_d = i_inc;
        end
        k_d = k_inc;
        if (k_inc == hi_q) begin
          if (hi_q == n_q) begin
            // end of pass: swap buffers, then double the run width or go to output once it covers the run
            src_d = !src_q;
            i_d   = '0;
            if (w2 >= {1'b0, n_q}) begin
              state_d = ST_OUT;
            end else begin
              w_d   = w2[CW-1:0];
              mid_d = min_cnt(w2, n_q);
              hi_d  = min_cnt(w2 << 1, n_q);
              j_d   = min_cnt(w2, n_q);
              k_d   = '0;
            end
          end else begin
            mid_d = min_cnt(sum_mid, n_q);
            hi_d  = min_cnt(sum_hi, n_q);
            i_d   = hi_q;
            j_d   = min_cnt(sum_mid, n_q);
            k_d   = hi_q;
          end
        end
      end

      ST_OUT: begin
        if (adv) begin
          ov_d    = 1'b1;
          oval_d  = va;
          ofin_d  = i_inc == n_q;
          odrop_d = drop_q;
          i_d     = i_inc;
          if (i_inc == n_q) begin
            state_d = ST_LOAD;
          end
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // a read of the entry written at the same edge takes the new data
  always_ff @(posedge clk_i) begin
    if (wa_en) begin
      mem_a[w_addr] <= w_data;
    end
    rd_a_i_q <= (wa_en && (w_addr == ra_i)) ? w_data : mem_a[ra_i];
    rd_a_j_q <= (wa_en && (w_addr == ra_j)) ? w_data : mem_a[ra_j];
  end

  always_ff @(posedge clk_i) begin
    if (wb_en) begin
      mem_b[w_addr] <= w_data;
    end
    rd_b_i_q <= (wb_en && (w_addr == ra_i)) ? w_data : mem_b[ra_i];
    rd_b_j_q <= (wb_en && (w_addr == ra_j)) ? w_data : mem_b[ra_j];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      n_q     <= '0;
      drop_q  <= 1'b0;
      w_q     <= '0;
      mid_q   <= '0;
      hi_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      src_q   <= 1'b0;
      ov_q    <= 1'b0;
      oval_q  <= '0;
      ofin_q  <= 1'b0;
      odrop_q <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      drop_q  <= drop_d;
      w_q     <= w_d;
      mid_q   <= mid_d;
      hi_q    <= hi_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      src_q   <= src_d;
      ov_q    <= ov_d;
      oval_q  <= oval_d;
      ofin_q  <= ofin_d;
      odrop_q <= odrop_d;
    end
  end

  assign out_valid_o    = ov_q;
  assign sorted_value_o = oval_q;
  assign final_res_o    = ofin_q;
  assign dropped_o      = odrop_q;

endmodule

FILE: src/merge_sort_engine_unit.sv
// channel | direction | handshake                 | payload
// input   | in        | in_valid_i / in_stall_o   | value_i, last_i
// output  | out       | out_valid_o / out_stall_i | sorted_value_o, final_res_o, dropped_o
//
// loading accepts one transaction per cycle through a two-entry queue, unless the queue is full
// a run of n values then goes through the setup state and ceil(log2 n) merge passes,
// each writing the merged values through the single write port of the merge buffers,
// then the output state emits the sorted run, held back by out_stall_i
// input is stalled whenever the queue is full; it fills while a run is sorted or emitted
// rst_ni clears the run count, queue and sequencer; the buffers keep no reset
module merge_sort_engine_unit #(
  parameter int unsigned MAX_ITEMS = mse_pkg::MAX_ITEMS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [mse_pkg::DATA_W-1:0] value_i,
  input  logic                              last_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [mse_pkg::DATA_W-1:0] sorted_value_o,
  output logic                              final_res_o,
  output logic                              dropped_o
);

  mse_pkg::q_entry_t push_entry, pop_entry;
  logic              q_push, q_full, q_valid, q_stall;

  mse_front #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .value_i    (value_i),
    .last_i     (last_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (push_entry)
  );

  mse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .stall_i (q_stall),
    .entry_o (pop_entry)
  );

  mse_back #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_stall_o      (q_stall),
    .q_entry_i      (pop_entry),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sorted_value_o (sorted_value_o),
    .final_res_o    (final_res_o),
    .dropped_o      (dropped_o)
  );

endmodule

FILE: bench/testbench.sv
module testbench;

  localparam int unsigned DATA_W      = mse_pkg::DATA_W;
  localparam int unsigned MAX_ITEMS   = mse_pkg::MAX_ITEMS_DEF;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          DRAIN_CYCLES = 600;
  localparam int          RANDOM_ITEMS = 470;

  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef enum int unsigned {
    FILL_FULL_RANGE,
    FILL_SMALL_DUPS,
    FILL_EXTREMES,
    FILL_MIXED
  } fill_kind_e;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_e;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } sort_item_t;

  typedef struct {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
    logic                     dropped;
  } sorted_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     last_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] sorted_value_o;
  logic                     final_res_o;
  logic                     dropped_o;

  sort_item_t               pending_items [$];
  sorted_result_t           expected_sorted [$];
  logic signed [DATA_W-1:0] run_values [$];
  logic                     run_overflow = 1'b0;
  int                       error_count = 0;
  int                       cycle_count = 0;

  // driver burst state
  int          burst_left = 0;
  int          gap_left = 0;
  sort_item_t  next_item;

  // receiver stall state
  stall_mode_e    stall_mode = STALL_NONE;
  int             stall_mode_left = 0;
  int             stall_phase = 0;
  sorted_result_t want;

  merge_sort_engine_unit #(
    .MAX_ITEMS(MAX_ITEMS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_i       (value_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sorted_value_o(sorted_value_o),
    .final_res_o   (final_res_o),
    .dropped_o     (dropped_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // collect one accepted value; on the closing value sort the run and queue its results
  function automatic void absorb_value(input logic signed [DATA_W-1:0] v, input logic is_last);
    logic signed [DATA_W-1:0] ordered [$];
    logic signed [DATA_W-1:0] key;
    sorted_result_t           res;
    int                       j;
    if (run_values.size() < MAX_ITEMS) begin
      run_values.push_back(v);
    end else begin
      run_overflow = 1'b1;
    end
    if (!is_last) return;
    ordered = run_values;
    for (int i = 1; i < ordered.size(); i++) begin
      key = ordered[i];
      j = i - 1;
      while (j >= 0 && ordered[j] > key) begin
        ordered[j+1] = ordered[j];
        j--;
      end
      ordered[j+1] = key;
    end
    for (int k = 0; k < ordered.size(); k++) begin
      res.sorted_value = ordered[k];
      res.final_res    = (k == ordered.size() - 1);
      res.dropped      = run_overflow;
      expected_sorted.push_back(res);
    end
    run_values.delete();
    run_overflow = 1'b0;
  endfunction

  task automatic queue_value(input logic signed [DATA_W-1:0] v, input logic is_last);
    sort_item_t it;
    it.value = v;
    it.last  = is_last;
    pending_items.push_back(it);
  endtask

  // driver: bursts of transactions separated by random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        absorb_value(value_i, last_i);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (burst_left != 0 && pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          value_i    <= next_item.value;
          last_i     <= next_item.last;
          in_valid_i <= 1'b1;
          burst_left--;
        end else begin
          in_valid_i <= 1'b0;
          if (burst_left == 0 && gap_left != 0) gap_left--;
        end
      end
    end
  end

  // monitor: check each accepted result and drive the stall pattern
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_sorted.size() == 0) begin
        $error("unexpected transaction: sorted_value %0d", sorted_value_o);
        error_count++;
      end else begin
        want = expected_sorted.pop_front();
        if (sorted_value_o !== want.sorted_value) begin
          $error("sorted_value: expected %0d, actual %0d", want.sorted_value, sorted_value_o);
          error_count++;
        end
        if (final_res_o !== want.final_res) begin
          $error("final_res: expected %0b, actual %0b", want.final_res, final_res_o);
          error_count++;
        end
        if (dropped_o !== want.dropped) begin
          $error("dropped: expected %0b, actual %0b", want.dropped, dropped_o);
          error_count++;
        end
      end
    end
    if (stall_mode_left == 0) begin
      stall_mode      = stall_mode_e'($urandom_range(0, 3));
      stall_mode_left = $urandom_range(16, 96);
    end
    stall_mode_left--;
    stall_phase++;
    case (stall_mode)
      STALL_NONE:     out_stall_i <= 1'b0;
      STALL_LIGHT:    out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_PERIODIC: out_stall_i <= (stall_phase % 3 != 0);
      default:        out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  initial begin
    fill_kind_e               fill;
    int                       run_len;
    int                       total;
    int                       run_idx;
    logic signed [DATA_W-1:0] v;

    // single value, most negative
    queue_value(VAL_MIN, 1'b1);
    // two values, extremes reversed
    queue_value(VAL_MAX, 1'b0);
    queue_value(VAL_MIN, 1'b1);
    // sign boundaries and alternating bit patterns
    queue_value(32'sd0, 1'b0);
    queue_value(-32'sd1, 1'b0);
    queue_value(32'sd1, 1'b0);
    queue_value(VAL_MAX, 1'b0);
    queue_value(VAL_MIN, 1'b0);
    queue_value(32'sh5555_5555, 1'b0);
    queue_value(32'shAAAA_AAAA, 1'b1);
    // repeated values
    queue_value(32'sd7, 1'b0);
    queue_value(-32'sd3, 1'b0);
    queue_value(32'sd7, 1'b0);
    queue_value(32'sd7, 1'b0);
    queue_value(-32'sd3, 1'b0);
    queue_value(32'sd0, 1'b1);
    // descending input
    queue_value(32'sd4, 1'b0);
    queue_value(32'sd3, 1'b0);
    queue_value(32'sd2, 1'b0);
    queue_value(32'sd1, 1'b1);

    total   = 0;
    run_idx = 0;
    while (total < RANDOM_ITEMS) begin
      // first one run past capacity with the closing value dropped, then one exactly full
      if (run_idx == 0) run_len = MAX_ITEMS + 1;
      else if (run_idx == 1) run_len = MAX_ITEMS;
      else begin
        case ($urandom_range(0, 19))
          0:       run_len = MAX_ITEMS;
          1:       run_len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 16);
          2:       run_len = $urandom_range(21, MAX_ITEMS - 1);
          default: run_len = $urandom_range(1, 20);
        endcase
      end
      fill = fill_kind_e'($urandom_range(0, 3));
      for (int i = 0; i < run_len; i++) begin
        case (fill)
          FILL_FULL_RANGE: v = $urandom;
          FILL_SMALL_DUPS: v = $signed($urandom_range(0, 15)) - 8;
          FILL_EXTREMES: begin
            case ($urandom_range(0, 3))
              0:       v = VAL_MIN;
              1:       v = VAL_MAX;
              2:       v = 32'sd0;
              default: v = -32'sd1;
            endcase
          end
          default: v = ($urandom_range(0, 1) == 0) ? $signed($urandom)
                                                   : $signed($urandom_range(0, 7)) - 4;
        endcase
        queue_value(v, i == run_len - 1);
      end
      total += run_len;
      run_idx++;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_sorted.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $error("timeout with %0d results outstanding", expected_sorted.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
